// ===== rtl/crc16_frame_append_check_defines.svh =====
// Assertion macros shared by the frame CRC block.
`ifndef CRC16_FRAME_APPEND_CHECK_DEFINES_SVH
`define CRC16_FRAME_APPEND_CHECK_DEFINES_SVH

// Same-cycle implication, clocked on clk, masked during reset.
`define CRCFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, masked during reset.
`define CRCFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/crcfa_pkg.sv =====
package crcfa_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

    // Frame status codes reported on the end beat in check mode
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_SHORT    = 2'd2;

    // Operating modes
    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;

    // Most beats one input byte can produce
    localparam int GROUP_DEPTH = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic [1:0] status;
    } item_t;

    // Beats produced by one input byte, oldest in items[0]
    typedef struct packed {
        logic [1:0] cnt;
        item_t [GROUP_DEPTH-1:0] items;
    } group_t;

    // Reflected CRC-16 update over one byte
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/crcfa_in_if.sv =====
interface crcfa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, output data_byte, output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

// ===== rtl/crcfa_out_if.sv =====
interface crcfa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [1:0] status;

    modport source (output valid, output out_byte, output byte_valid, output frame_end,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input frame_end,
                    input status, output ready);
endinterface

// ===== rtl/crc16_frame_append_check.sv =====
// Channel   | Dir | Beat contents
// in_ch     | in  | data_byte, frame_last
// out_ch    | out | out_byte, byte_valid, frame_end, status
// cfg       | in  | cfg_we, cfg_wdata (mode)
//
// One input byte is accepted per cycle while ready is high; its result beats appear in the next cycle.
// An appended frame's last byte yields three beats, which the output group
// register drains one per cycle while out_ch is ready, so input stalls until the last of them leaves.
// Ready is high while the output group is empty or its final beat leaves.
// Reset (async, active low) selects append mode, CRC 0xFFFF, empty hold.
// A mode write drops any partial frame and reloads the CRC.
`include "crc16_frame_append_check_defines.svh"

module crc16_frame_append_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    crcfa_in_if.sink    in_ch,
    crcfa_out_if.source out_ch
);
    import crcfa_pkg::*;

    logic        mode_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  hold0_reg;
    logic [7:0]  hold0_next;
    logic [7:0]  hold1_reg;
    logic [7:0]  hold1_next;
    logic [1:0]  hold_cnt_reg;
    logic [1:0]  hold_cnt_next;

    logic        accept;
    logic        load_ok;
    logic        hold_full;
    logic [7:0]  fold_byte;
    logic [15:0] crc_fold_out;
    logic [15:0] rx_crc;
    logic [15:0] cmp_crc;
    logic [1:0]  end_status;
    item_t       byte_item;
    item_t       end_item;
    group_t      group;

    assign in_ch.ready = load_ok;
    assign accept      = in_ch.valid && in_ch.ready;

    // Pick the byte to fold: the incoming one in append mode, the oldest held one in check mode
    assign hold_full    = (hold_cnt_reg == 2'd2);
    assign fold_byte    = (mode_reg == MODE_APPEND) ? in_ch.data_byte : hold0_reg;
    assign crc_fold_out = crc_fold(crc_reg, fold_byte);

    // Compare the trailing two bytes against the running CRC
    always_comb
    begin
        if (hold_full)
        begin
            rx_crc  = {in_ch.data_byte, hold1_reg};
            cmp_crc = crc_fold_out;
        end
        else
        begin
            rx_crc  = {in_ch.data_byte, hold0_reg};
            cmp_crc = crc_reg;
        end
        if (hold_cnt_reg == 2'd0)
            end_status = STATUS_SHORT;
        else if (rx_crc == cmp_crc)
            end_status = STATUS_OK;
        else
            end_status = STATUS_MISMATCH;
    end

    // Build the result group for this byte
    always_comb
    begin
        byte_item  = '{out_byte: fold_byte, byte_valid: 1'b1, frame_end: 1'b0,
                       status: STATUS_OK};
        end_item   = '{out_byte: 8'h00, byte_valid: 1'b0, frame_end: 1'b1,
                       status: end_status};
        group      = '0;
        if (mode_reg == MODE_APPEND)
        begin
            group.items[0] = byte_item;
            group.items[1] = '{out_byte: crc_fold_out[7:0], byte_valid: 1'b1,
                               frame_end: 1'b0, status: STATUS_OK};
            group.items[2] = '{out_byte: crc_fold_out[15:8], byte_valid: 1'b1,
                               frame_end: 1'b1, status: STATUS_OK};
            group.cnt      = in_ch.frame_last ? 2'd3 : 2'd1;
        end
        else
        begin
            group.items[0] = hold_full ? byte_item : end_item;
            group.items[1] = end_item;
            group.cnt      = {1'b0, hold_full} + {1'b0, in_ch.frame_last};
        end
    end

    // Advance CRC and hold state on each accepted byte, or reload them on a mode write
    always_comb
    begin
        crc_next      = crc_reg;
        hold0_next    = hold0_reg;
        hold1_next    = hold1_reg;
        hold_cnt_next = hold_cnt_reg;
        if (cfg_we)
        begin
            crc_next      = CRC_INIT;
            hold_cnt_next = 2'd0;
        end
        else if (accept)
        begin
            if (mode_reg == MODE_APPEND)
            begin
                crc_next = in_ch.frame_last ? CRC_INIT : crc_fold_out;
            end
            else if (hold_full)
            begin
                crc_next      = in_ch.frame_last ? CRC_INIT : crc_fold_out;
                hold0_next    = hold1_reg;
                hold1_next    = in_ch.data_byte;
                hold_cnt_next = in_ch.frame_last ? 2'd0 : 2'd2;
            end
            else
            begin
                if (hold_cnt_reg[0])
                    hold1_next = in_ch.data_byte;
                else
                    hold0_next = in_ch.data_byte;
                hold_cnt_next = in_ch.frame_last ? 2'd0 : hold_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_APPEND;
            crc_reg      <= CRC_INIT;
            hold0_reg    <= 8'h00;
            hold1_reg    <= 8'h00;
            hold_cnt_reg <= 2'd0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;
            crc_reg      <= crc_next;
            hold0_reg    <= hold0_next;
            hold1_reg    <= hold1_next;
            hold_cnt_reg <= hold_cnt_next;
        end
    end

    // Output group register
    crcfa_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .group_in (group),
        .load_ok  (load_ok),
        .out_ch   (out_ch)
    );

    `CRCFA_ASSERT_NOW(a_hold_range, 1'b1, hold_cnt_reg != 2'd3, "hold count beyond two")
    `CRCFA_ASSERT_NEXT(a_frame_reload, accept && in_ch.frame_last && !cfg_we, (crc_reg == CRC_INIT) && (hold_cnt_reg == 2'd0), "state not reloaded after frame end")

endmodule

// ===== rtl/crcfa_obuf.sv =====
`include "crc16_frame_append_check_defines.svh"

module crcfa_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  crcfa_pkg::group_t group_in,
    output logic              load_ok,
    crcfa_out_if.source       out_ch
);
    import crcfa_pkg::*;

    logic [1:0]                cnt_reg;
    logic [1:0]                cnt_next;
    item_t [GROUP_DEPTH-1:0]   items_reg;
    item_t [GROUP_DEPTH-1:0]   items_next;
    logic                      pop;

    // Present the oldest held beat
    assign out_ch.valid      = (cnt_reg != 2'd0);
    assign out_ch.out_byte   = items_reg[0].out_byte;
    assign out_ch.byte_valid = items_reg[0].byte_valid;
    assign out_ch.frame_end  = items_reg[0].frame_end;
    assign out_ch.status     = items_reg[0].status;

    assign pop     = out_ch.valid && out_ch.ready;
    // Take a new group when empty or when the last held beat leaves now
    assign load_ok = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    // Load a fresh group or advance the held one
    always_comb
    begin
        cnt_next   = cnt_reg;
        items_next = items_reg;
        if (load && (group_in.cnt != 2'd0))
        begin
            cnt_next   = group_in.cnt;
            items_next = group_in.items;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
            for (int i = 0; i < GROUP_DEPTH - 1; i++)
            begin
                items_next[i] = items_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
    end

    `CRCFA_ASSERT_NOW(a_load_when_free, load && (group_in.cnt != 2'd0), load_ok, "group loaded over pending beats")
    `CRCFA_ASSERT_NOW(a_end_is_last, out_ch.valid && out_ch.frame_end, cnt_reg == 2'd1, "frame end beat not last of its group")
    `CRCFA_ASSERT_NEXT(a_pop_drains, pop && !load, cnt_reg == $past(cnt_reg) - 2'd1, "beat count did not drop after a pop")

endmodule
